>>> src/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put;        // write put_byte into the buffer
    logic [7:0] put_byte;
    logic       cnt_inc;    // advance message length
    logic       start;      // begin a compression
    logic       reload;     // load initial values, clear length
    logic       emit_load;  // snapshot the chaining words for output
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0]  fill;
    logic        busy;
    logic [63:0] bit_len;
  } dp_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> src/sha256_byte_stream_hasher.sv
// A data word is taken while the controller is idle; every 64th byte starts a
// compression run by the single round unit, during which input is held off.
// A finish word is followed by padding and length bytes and one or two
// compressions, then the eight digest words leave one per cycle as the
// sink takes them.
// Reset (rst_n low, synchronous) loads the initial hash, clears the counters.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::ctl_cmd_t cmd;
  sha_pkg::dp_stat_t stat;
  logic [31:0] chain [8];

  // The controller sequences bytes, padding, length and digest output.
  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_data_byte,
    .out_valid, .out_ready, .out_word_index, .out_last_word,
    .stat, .cmd
  );

  // The datapath holds the buffer, counters and the shared round unit.
  sha_datapath u_dp (.clk, .rst_n, .cmd, .stat, .chain_out(chain));

  assign out_digest_word = chain[out_word_index];

endmodule

>>> src/sha_datapath.sv
module sha_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::ctl_cmd_t   cmd,
  output sha_pkg::dp_stat_t   stat,
  output logic [31:0]         chain_out [8]
);

  // Schedule window: the last sixteen words, oldest at index 0. It is filled
  // byte by byte as data arrives, so a compression starts with it loaded.
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] snap_r [8];
  logic [5:0]  fill_r;
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic        busy_r;

  logic [31:0] s0, s1, wnew, big1, ch, t1, big0, mj, t2;

  always_comb begin
    s0   = sha_pkg::ror32(w_r[1], 7) ^ sha_pkg::ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = sha_pkg::ror32(w_r[14], 17) ^ sha_pkg::ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    big1 = sha_pkg::ror32(v_r[4], 6) ^ sha_pkg::ror32(v_r[4], 11)
         ^ sha_pkg::ror32(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + sha_pkg::ROUND_K[rnd_r] + w_r[0];
    big0 = sha_pkg::ror32(v_r[0], 2) ^ sha_pkg::ror32(v_r[0], 13)
         ^ sha_pkg::ror32(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + mj;
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
    for (int i = 0; i < 15; i++) begin
      w_nxt[i] = w_r[i + 1];
    end
    w_nxt[15] = wnew;
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], cmd.put_byte};
    end else if (busy_r) begin
      w_r <= w_nxt;
    end
    if (cmd.start) begin
      v_r <= h_r;
    end else if (busy_r) begin
      v_r <= v_nxt;
    end
    if (cmd.emit_load) begin
      snap_r <= h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= sha_pkg::INIT_H;
      fill_r <= '0;
      cnt_r  <= '0;
      rnd_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cmd.put) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_nxt[i];
          end
        end
      end
      if (cmd.reload) begin
        h_r   <= sha_pkg::INIT_H;
        cnt_r <= '0;
      end
    end
  end

  assign stat.fill    = fill_r;
  assign stat.busy    = busy_r;
  assign stat.bit_len = {cnt_r, 3'b000};
  assign chain_out    = snap_r;

endmodule

>>> src/sha_ctrl.sv
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_word_index,
  output logic               out_last_word,
  input  sha_pkg::dp_stat_t  stat,
  output sha_pkg::ctl_cmd_t  cmd
);

  sha_pkg::state_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;  // compression belongs to the final block

  // Set while a finish is in progress, so a compression started by padding
  // returns to padding instead of to idle.
  logic pad_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      idx_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put = 1'b1;
          if (!in_kind) begin
            cmd.put_byte = in_data_byte;
            cmd.cnt_inc  = 1'b1;
            fin_nxt      = 1'b0;
            if (stat.fill == 6'd63) begin
              cmd.start = 1'b1;
              state_nxt = sha_pkg::ST_COMP;
            end
          end else begin
            cmd.put_byte = sha_pkg::PAD_BYTE;
            fin_nxt      = 1'b0;
            if (stat.fill == 6'd63) begin
              cmd.start = 1'b1;
              state_nxt = sha_pkg::ST_COMP;
            end else if (stat.fill + 6'd1 == sha_pkg::LEN_POS) begin
              state_nxt = sha_pkg::ST_LEN;
            end else begin
              state_nxt = sha_pkg::ST_PAD;
            end
            idx_nxt = '0;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        cmd.put = 1'b1;
        if (stat.fill == 6'd63) begin
          cmd.start = 1'b1;
          state_nxt = sha_pkg::ST_COMP;
        end else if (stat.fill + 6'd1 == sha_pkg::LEN_POS) begin
          state_nxt = sha_pkg::ST_LEN;
        end
      end
      sha_pkg::ST_LEN: begin
        cmd.put      = 1'b1;
        cmd.put_byte = stat.bit_len[8 * (7 - idx_r) +: 8];
        idx_nxt      = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          cmd.start = 1'b1;
          fin_nxt   = 1'b1;
          idx_nxt   = '0;
          state_nxt = sha_pkg::ST_COMP;
        end
      end
      sha_pkg::ST_COMP: begin
        // Padding continues after a block that the padding itself filled.
        if (!stat.busy) begin
          if (fin_r) begin
            cmd.emit_load = 1'b1;
            cmd.reload    = 1'b1;
            state_nxt     = sha_pkg::ST_EMIT;
          end else if (pad_pend_r) begin
            state_nxt = sha_pkg::ST_PAD;
          end else begin
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_pend_r <= 1'b0;
    end else if (state_r == sha_pkg::ST_IDLE && in_valid && in_kind) begin
      pad_pend_r <= 1'b1;
    end else if (state_r == sha_pkg::ST_EMIT) begin
      pad_pend_r <= 1'b0;
    end
  end

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

endmodule

>>> src/sha_checker.sv
module sha_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag mismatch");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=> out_valid
      && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of order");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during digest");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_index))
    else $error("output dropped");

endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (.*);

>>> dv/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Shadow copy of the hash state, kept in step with accepted words.
  logic [31:0]  chain_h [8];
  logic [7:0]   block_buf [64];
  int unsigned  fill_bytes;
  logic [60:0]  msg_bytes;

  digest_beat_t digest_queue [$];
  int           mismatch_count = 0;

  // Sink and source behavior controls.
  bit           sink_idle_en = 1'b1;
  int           sink_hold_cycles = 0;
  bit           source_idle_en = 1'b1;

  sha256_byte_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of block_buf into chain_h.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sha_pkg::ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    block_buf[fill_bytes] = b;
    fill_bytes++;
    if (fill_bytes == 64) begin
      compress_block();
      fill_bytes = 0;
    end
  endfunction

  function automatic void reload_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = sha_pkg::INIT_H[i];
    fill_bytes = 0;
    msg_bytes = '0;
  endfunction

  // Update the shadow state for one accepted word; a finish queues the digest.
  function automatic void absorb_word(input logic kind, input logic [7:0] b);
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (!kind) begin
      append_byte(b);
      msg_bytes = msg_bytes + 61'd1;
    end else begin
      bit_len = {msg_bytes, 3'b000};
      append_byte(sha_pkg::PAD_BYTE);
      while (fill_bytes != sha_pkg::LEN_POS) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.word = chain_h[i];
        beat.index = 3'(i);
        beat.last = (i == 7);
        digest_queue.push_back(beat);
      end
      reload_hash();
    end
  endfunction

  // Send one word, with an optional random burst of idle cycles first. The
  // valid line stays up after acceptance until the next word replaces it or
  // the sender stops.
  task automatic send_word(input logic kind, input logic [7:0] b);
    if (source_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(kind, b);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_word(1'b0, 8'($urandom));
    send_word(1'b1, 8'($urandom));
  endtask

  task automatic wait_digests_done();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Sink ready: random idle bursts, or a long counted hold when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      sink_hold_cycles <= sink_hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold_cycles <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker: compare every accepted digest word with the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest word %h index %0d", out_digest_word, out_word_index);
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_digest_word !== exp_beat.word || out_word_index !== exp_beat.index ||
            out_last_word !== exp_beat.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     exp_beat.word, exp_beat.index, exp_beat.last,
                     out_digest_word, out_word_index, out_last_word);
        end
      end
    end
  end

  // Directed: empty message, extreme bytes, the message abc and a short random one.
  task automatic test_directed();
    send_word(1'b1, 8'hff);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hff);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h61);
    send_word(1'b0, 8'h62);
    send_word(1'b0, 8'h63);
    send_word(1'b1, 8'h55);
    send_message(3);
    wait_digests_done();
  endtask

  // Length 55 just fits one padded block; 56 and 64 cross into a second padding block.
  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    send_message(64);
    wait_digests_done();
  endtask

  // Sink holds off a long time while the source keeps offering words.
  task automatic test_backpressure();
    sink_hold_cycles = 300;
    send_message(2);
    send_message(5);
    send_message(1);
    wait_digests_done();
  endtask

  task automatic test_random_messages();
    for (int m = 0; m < 5; m++) begin
      send_message($urandom_range(0, 12));
    end
    wait_digests_done();
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    source_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (int m = 0; m < 3; m++) send_message($urandom_range(0, 8));
    wait_digests_done();
  endtask

  initial begin
    reload_hash();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_block_boundaries();
    test_backpressure();
    test_random_messages();
    test_full_rate();
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
